// ----- design/ccar_pkg.sv -----
// Package for the chunked CRC-32 artifact receiver.
// Holds request/response types, opcode and slot codes, and the CRC byte update.
// No dependencies.
package ccar_pkg;

    localparam int SIZE_W = 17;
    localparam int CRC_W  = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_BYTE   = 2'd1,
        OP_ABORT  = 2'd2,
        OP_VERIFY = 2'd3
    } op_t;

    localparam logic [1:0] SLOT_NONE = 2'd0;
    localparam logic [1:0] SLOT_A    = 2'd1;
    localparam logic [1:0] SLOT_B    = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_REJ = 1'b1;

    typedef struct packed {
        op_t                opcode;
        logic [7:0]         instance_id;
        logic [SIZE_W-1:0]  artifact_size;
        logic [1:0]         active_slot;
        logic [7:0]         data_byte;
        logic               chunk_end;
        logic [CRC_W-1:0]   expected_crc;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [1:0]         target_slot;
        logic [CRC_W-1:0]   final_crc;
        logic [SIZE_W-1:0]  received_total;
        logic               complete;
        logic               crc_match;
    } rsp_t;

    // reflected CRC-32, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        return c;
    endfunction

endpackage

// ----- design/chunked_crc32_artifact_receiver.sv -----
// Chunked CRC-32 artifact receiver, top level.
// Depends on ccar_pkg for request/response types and the CRC byte update.
//
// Usage:
//   Requests arrive on req/req_valid/req_ready: begin, chunk byte, abort,
//   verify. Each chunk byte folds into a tentative reflected CRC-32; the byte
//   flagged chunk_end closes the chunk, which commits only when staging is
//   active and its length equals min(CHUNK_BYTES, bytes still missing).
//   Responses leave on rsp/rsp_valid/rsp_ready: one per begin, abort, verify
//   and chunk_end byte; chunk bytes without chunk_end give none.
//   Latency: a response is valid the cycle after its request is taken.
//   Throughput: one request per cycle; the state update and CRC byte step
//   are combinational XOR logic feeding the state and response registers.
//   The response register is the only buffer: while it holds an untaken
//   response and rsp_ready is low, req_ready is low; otherwise requests
//   are taken every cycle.
//   Reset (rst_n low, asynchronous) clears staging, sets both CRCs to all
//   ones, and empties the response register. No clearing pass is needed.
module chunked_crc32_artifact_receiver
    import ccar_pkg::*;
#(
    parameter int CHUNK_BYTES        = 256,
    parameter int MAX_ARTIFACT_BYTES = 65536
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(CHUNK_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(CHUNK_BYTES + 1);
    localparam logic [SIZE_W-1:0] CHUNK_SZ = SIZE_W'(CHUNK_BYTES);
    localparam logic [SIZE_W:0] MAX_SZ =
        (MAX_ARTIFACT_BYTES >= (1 << SIZE_W)) ? {1'b0, {SIZE_W{1'b1}}}
                                             : (SIZE_W+1)'(MAX_ARTIFACT_BYTES);

    logic              staging_reg, staging_next;
    logic [1:0]        slot_reg, slot_next;
    logic [SIZE_W-1:0] total_reg, total_next;
    logic [CRC_W-1:0]  ccrc_reg, ccrc_next;
    logic [SIZE_W-1:0] cbytes_reg, cbytes_next;
    logic [CRC_W-1:0]  tcrc_reg, tcrc_next;
    logic [CNT_W-1:0]  tcnt_reg, tcnt_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              take;
    logic              emit;
    logic              status;
    logic [CRC_W-1:0]  crc_upd;
    logic [CNT_W-1:0]  cnt_upd;
    logic [SIZE_W-1:0] remain;
    logic [SIZE_W-1:0] exp_len;
    logic [SIZE_W-1:0] cnt_ext;
    logic              chunk_ok;
    logic              complete;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign take      = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign crc_upd = crc_byte(tcrc_reg, req.data_byte);
    assign cnt_upd = (tcnt_reg == CNT_SAT) ? tcnt_reg : tcnt_reg + CNT_W'(1);
    assign cnt_ext = SIZE_W'(cnt_upd);
    // committed bytes track the chunk offset until the short last chunk
    assign remain  = (total_reg > cbytes_reg) ? total_reg - cbytes_reg : '0;
    assign exp_len = (remain > CHUNK_SZ) ? CHUNK_SZ : remain;
    assign chunk_ok = staging_reg && (cnt_ext != '0) && (cnt_ext == exp_len);

    always_comb
    begin
        staging_next = staging_reg;
        slot_next    = slot_reg;
        total_next   = total_reg;
        ccrc_next    = ccrc_reg;
        cbytes_next  = cbytes_reg;
        tcrc_next    = tcrc_reg;
        tcnt_next    = tcnt_reg;
        status       = STATUS_REJ;
        emit         = 1'b1;
        unique case (req.opcode)
            OP_BEGIN:
            begin
                if (req.instance_id != 8'd0 && {1'b0, req.artifact_size} <= MAX_SZ)
                begin
                    staging_next = 1'b1;
                    slot_next    = (req.active_slot == SLOT_A) ? SLOT_B : SLOT_A;
                    total_next   = req.artifact_size;
                    ccrc_next    = CRC_ONES;
                    cbytes_next  = '0;
                    tcrc_next    = CRC_ONES;
                    tcnt_next    = '0;
                    status       = STATUS_OK;
                end
            end
            OP_BYTE:
            begin
                tcrc_next = crc_upd;
                tcnt_next = cnt_upd;
                emit      = req.chunk_end;
                if (req.chunk_end)
                begin
                    if (chunk_ok)
                    begin
                        ccrc_next   = crc_upd;
                        cbytes_next = cbytes_reg + cnt_ext;
                        status      = STATUS_OK;
                    end
                    tcrc_next = chunk_ok ? crc_upd : ccrc_reg;
                    tcnt_next = '0;
                end
            end
            OP_ABORT:
            begin
                if (staging_reg)
                begin
                    staging_next = 1'b0;
                    slot_next    = SLOT_NONE;
                    total_next   = '0;
                    ccrc_next    = CRC_ONES;
                    cbytes_next  = '0;
                    tcrc_next    = CRC_ONES;
                    tcnt_next    = '0;
                    status       = STATUS_OK;
                end
            end
            OP_VERIFY:
            begin
                status = staging_reg ? STATUS_OK : STATUS_REJ;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign complete = staging_next && (cbytes_next == total_next);

    always_comb
    begin
        rsp_next.status         = status;
        rsp_next.target_slot    = slot_next;
        rsp_next.final_crc      = ccrc_next ^ CRC_ONES;
        rsp_next.received_total = cbytes_next;
        rsp_next.complete       = complete;
        rsp_next.crc_match      = (req.opcode == OP_VERIFY) && complete &&
                                  ((ccrc_next ^ CRC_ONES) == req.expected_crc);
        if (take)
        begin
            rsp_valid_next = emit;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && !rsp_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staging_reg   <= 1'b0;
            slot_reg      <= SLOT_NONE;
            total_reg     <= '0;
            ccrc_reg      <= CRC_ONES;
            cbytes_reg    <= '0;
            tcrc_reg      <= CRC_ONES;
            tcnt_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (take)
            begin
                staging_reg <= staging_next;
                slot_reg    <= slot_next;
                total_reg   <= total_next;
                ccrc_reg    <= ccrc_next;
                cbytes_reg  <= cbytes_next;
                tcrc_reg    <= tcrc_next;
                tcnt_reg    <= tcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
